### sv/u8l9_pkg.sv
// Shared types, constants and the Latin-9 mapping function of the UTF-8 to Latin-9 decoder.
package u8l9_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int LEN_WIDTH   = 16;
	localparam int ACC_WIDTH   = 31;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [LEN_WIDTH-1:0]   LEN_MAX   = {LEN_WIDTH{1'b1}};

	// Continuation byte pattern and the six-bit payload mask.
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_MATCH = 8'h80;
	localparam logic [7:0] PAYLOAD6   = 8'h3F;

	// Code points that Latin-9 places in the upper half.
	localparam logic [ACC_WIDTH-1:0] CP_OE_UPPER = ACC_WIDTH'(32'h0152);
	localparam logic [ACC_WIDTH-1:0] CP_OE_LOWER = ACC_WIDTH'(32'h0153);
	localparam logic [ACC_WIDTH-1:0] CP_S_CARON  = ACC_WIDTH'(32'h0160);
	localparam logic [ACC_WIDTH-1:0] CP_s_CARON  = ACC_WIDTH'(32'h0161);
	localparam logic [ACC_WIDTH-1:0] CP_Y_DIAER  = ACC_WIDTH'(32'h0178);
	localparam logic [ACC_WIDTH-1:0] CP_Z_CARON  = ACC_WIDTH'(32'h017D);
	localparam logic [ACC_WIDTH-1:0] CP_z_CARON  = ACC_WIDTH'(32'h017E);
	localparam logic [ACC_WIDTH-1:0] CP_EURO     = ACC_WIDTH'(32'h20AC);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]           out_byte;
		logic                 byte_valid;
		logic                 end_of_string;
		logic [LEN_WIDTH-1:0] out_length;
	} out_item_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] code;
	} map_t;

	function automatic map_t map_latin9(input logic [ACC_WIDTH-1:0] cp);
		map_t r;
		r.ok   = 1'b1;
		r.code = cp[7:0];
		if (cp[ACC_WIDTH-1:8] != '0) begin
			case (cp)
				CP_OE_UPPER: r.code = 8'hBC;
				CP_OE_LOWER: r.code = 8'hBD;
				CP_S_CARON:  r.code = 8'hA6;
				CP_s_CARON:  r.code = 8'hA8;
				CP_Y_DIAER:  r.code = 8'hBE;
				CP_Z_CARON:  r.code = 8'hB4;
				CP_z_CARON:  r.code = 8'hB8;
				CP_EURO:     r.code = 8'hA4;
				default: begin
					r.ok   = 1'b0;
					r.code = 8'h00;
				end
			endcase
		end
		return r;
	endfunction

	function automatic logic [LEN_WIDTH-1:0] sat_len(input logic [COUNT_WIDTH-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'(LEN_MAX)) ? LEN_MAX : w[LEN_WIDTH-1:0];
	endfunction

endpackage

### sv/u8l9_in_if.sv
// Request channel that carries UTF-8 input bytes.
interface u8l9_in_if;
	import u8l9_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### sv/u8l9_out_if.sv
// Request channel that carries decoded Latin-9 results.
interface u8l9_out_if;
	import u8l9_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

### sv/u8l9_decode.sv
// Sequence state registers and the single-pass decode of one input byte.
module u8l9_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  u8l9_pkg::in_item_t  item,
	output logic                res_valid,
	output u8l9_pkg::out_item_t res
);
	import u8l9_pkg::*;

	logic [2:0]             pending_q;
	logic [ACC_WIDTH-1:0]   accum_q;
	logic                   cont_ok_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic [2:0]             pending_d;
	logic [ACC_WIDTH-1:0]   accum_d;
	logic                   cont_ok_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   emit;
	logic [7:0]             val;
	logic [7:0]             b;
	map_t                   mapped;

	assign b = item.in_byte;

	always_comb begin
		pending_d = pending_q;
		accum_d   = accum_q;
		cont_ok_d = cont_ok_q;
		emit      = 1'b0;
		val       = 8'h00;
		mapped    = '0;
		if (pending_q != 3'd0) begin
			if ((b & CONT_MASK) != CONT_MATCH) begin
				cont_ok_d = 1'b0;
			end
			accum_d   = {accum_q[ACC_WIDTH-7:0], b[5:0]};
			mapped    = map_latin9(accum_d);
			pending_d = pending_q - 3'd1;
			if (pending_d == 3'd0 && cont_ok_d) begin
				emit = mapped.ok;
				val  = mapped.code;
			end
		end else if (b[7] == 1'b0) begin
			emit = 1'b1;
			val  = b;
		end else if (b inside {[8'h80:8'hBF], 8'hFE, 8'hFF}) begin
			// Stray continuation or an invalid byte: nothing happens.
		end else begin
			cont_ok_d = 1'b1;
			if (b < 8'hE0) begin
				pending_d = 3'd1;
				accum_d   = ACC_WIDTH'(b[4:0]);
			end else if (b < 8'hF0) begin
				pending_d = 3'd2;
				accum_d   = ACC_WIDTH'(b[3:0]);
			end else if (b < 8'hF8) begin
				pending_d = 3'd3;
				accum_d   = ACC_WIDTH'(b[2:0]);
			end else if (b < 8'hFC) begin
				pending_d = 3'd4;
				accum_d   = ACC_WIDTH'(b[1:0]);
			end else begin
				pending_d = 3'd5;
				accum_d   = ACC_WIDTH'(b[0]);
			end
		end

		count_d = count_q;
		if (emit && count_q != COUNT_MAX) begin
			count_d = count_q + COUNT_WIDTH'(1);
		end

		res_valid          = emit || item.last;
		res.out_byte       = emit ? val : 8'h00;
		res.byte_valid     = emit;
		res.end_of_string  = item.last;
		res.out_length     = item.last ? sat_len(count_d) : '0;
	end

	// The end of a string puts every piece of state back to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
			accum_q   <= '0;
			cont_ok_q <= 1'b1;
			count_q   <= '0;
		end else if (advance) begin
			if (item.last) begin
				pending_q <= 3'd0;
				accum_q   <= '0;
				cont_ok_q <= 1'b1;
				count_q   <= '0;
			end else begin
				pending_q <= pending_d;
				accum_q   <= accum_d;
				cont_ok_q <= cont_ok_d;
				count_q   <= count_d;
			end
		end
	end
endmodule

### sv/u8l9_out_reg.sv
// Result register that drives the output channel.
module u8l9_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  u8l9_pkg::out_item_t res,
	output logic                free,
	u8l9_out_if.source          latin9
);
	import u8l9_pkg::*;

	logic      valid_q;
	out_item_t item_q;

	assign free         = !valid_q || latin9.ready;
	assign latin9.valid = valid_q;
	assign latin9.item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (latin9.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= res;
		end
	end
endmodule

### sv/utf8_to_latin9_stream_decoder.sv
// UTF-8 to Latin-9 decoder: a byte goes from the input register to the result register.
// Throughput: one byte per cycle; the input register stalls only when a byte
// that yields a result finds the result register still full.
// Reset clears all valid flags and the sequence state; payload registers are not reset.
module utf8_to_latin9_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	u8l9_in_if.sink    utf8,
	u8l9_out_if.source latin9
);
	import u8l9_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      res_valid;
	out_item_t res;
	logic      out_free;

	assign advance    = valid_s1 && (!res_valid || out_free);
	assign utf8.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (utf8.ready) begin
			valid_s1 <= utf8.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (utf8.valid && utf8.ready) begin
			item_s1 <= utf8.item;
		end
	end

	u8l9_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	u8l9_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.res    (res),
		.free   (out_free),
		.latin9 (latin9)
	);
endmodule
